>>> rtl/core/i2cms_pkg.sv
package i2cms_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 8;
	localparam int unsigned TICK_W          = 17;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 17'd100000;

	typedef enum logic [1:0] {
		ACT_BEGIN    = 2'd0,
		ACT_WRITE    = 2'd1,
		ACT_COMPLETE = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_READ     = 2'd1,
		KIND_WR_RD    = 2'd2,
		KIND_RESERVED = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START     = 4'd1,
		PH_ADDR_W    = 4'd2,
		PH_NEED_DATA = 4'd3,
		PH_DATA_W    = 4'd4,
		PH_RESTART   = 4'd5,
		PH_ADDR_R    = 4'd6,
		PH_DATA_R    = 4'd7,
		PH_STOP      = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_SEND    = 3'd4,
		CMD_RX_ACK  = 3'd5,
		CMD_RX_NACK = 3'd6,
		CMD_RELEASE = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ARG     = 3'd1,
		ST_STATE   = 3'd2,
		ST_NACK    = 3'd3,
		ST_TIMEOUT = 3'd4
	} status_t;

	typedef enum logic {
		REG_ENABLED = 1'b0,
		REG_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] kind;
		logic [6:0] tgt_addr;
		logic [7:0] wr_count;
		logic [7:0] rd_count;
		logic [7:0] data;
		logic       nack_seen;
	} in_item_t;

	typedef struct packed {
		logic [2:0] bus_cmd;
		logic [7:0] bus_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic [2:0] status;
		logic       busy_res;
	} out_item_t;

endpackage

>>> rtl/core/i2cms_if.sv
interface i2cms_in_if import i2cms_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface i2cms_out_if import i2cms_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface i2cms_cfg_if import i2cms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              index;
	logic [TICK_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/i2c_master_transaction_sequencer_core.sv
// an accepted item waits in the input register s1; the single-pass sequencer
// logic between it and the result register computes the result; throughput is
// one item per cycle, set by that logic, when the result register can take it
// reset: arst_n clears the channel to idle, disabled, timeout limit 100000,
// and empties both item registers
module i2c_master_transaction_sequencer_core import i2cms_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	i2cms_in_if.sink    evt,
	i2cms_out_if.source res,
	i2cms_cfg_if.sink   cfg
);

	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	// configuration registers
	logic              enabled_q;
	logic [TICK_W-1:0] timeout_limit_q;

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// sequencer state
	phase_t            phase_q;
	kind_t             txn_kind_q;
	logic [6:0]        target_addr_q;
	logic [COUNT_WIDTH-1:0] writes_left_q;
	logic [COUNT_WIDTH-1:0] reads_left_q;
	status_t           held_error_q;
	logic [TICK_W-1:0] wait_ticks_q;

	// result register
	logic      out_valid_q;
	out_item_t out_item_q;

	// next-state values
	phase_t            phase_n;
	kind_t             txn_kind_n;
	logic [6:0]        target_addr_n;
	logic [COUNT_WIDTH-1:0] writes_left_n;
	logic [COUNT_WIDTH-1:0] reads_left_n;
	status_t           held_error_n;
	logic [TICK_W-1:0] wait_ticks_n;
	out_item_t         result;

	logic advance;

	// the s1 item moves on when the result register is empty or being drained
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid = out_valid_q;
	assign res.item  = out_item_q;

	// config writes: the host must issue them with no item in flight; not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= 1'b0;
			timeout_limit_q <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_ENABLED: enabled_q       <= cfg.data[0];
				REG_TIMEOUT: timeout_limit_q <= cfg.data;
				default:     enabled_q       <= enabled_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			item_s1 <= evt.item;
		end
	end

	// one pass over the event: decide the command and the next phase
	always_comb begin
		logic [COUNT_WIDTH-1:0] wl;
		logic [COUNT_WIDTH-1:0] rl;
		logic [COUNT_WIDTH-1:0] rd_dec;
		logic [TICK_W-1:0]      ticks_inc;
		kind_t                  k;
		status_t                reject;

		wl        = COUNT_WIDTH'(item_s1.wr_count);
		rl        = COUNT_WIDTH'(item_s1.rd_count);
		rd_dec    = reads_left_q - CNT_ONE;
		ticks_inc = wait_ticks_q + TICK_W'(1);
		k         = kind_t'(item_s1.kind);
		reject    = ST_OK;

		phase_n       = phase_q;
		txn_kind_n    = txn_kind_q;
		target_addr_n = target_addr_q;
		writes_left_n = writes_left_q;
		reads_left_n  = reads_left_q;
		held_error_n  = held_error_q;
		wait_ticks_n  = wait_ticks_q;
		result        = '0;

		unique case (action_t'(item_s1.action))
			ACT_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					priority if (k == KIND_RESERVED) begin
						reject = ST_ARG;
					end else if (!enabled_q) begin
						reject = ST_STATE;
					end else if ((k != KIND_READ && wl == '0) ||
					             (k != KIND_WRITE && rl == '0)) begin
						reject = ST_ARG;
					end else begin
						reject = ST_OK;
					end
					if (reject != ST_OK) begin
						result.done_res = 1'b1;
						result.status   = reject;
					end else begin
						txn_kind_n     = k;
						target_addr_n  = item_s1.tgt_addr;
						writes_left_n  = (k == KIND_READ) ? '0 : wl;
						reads_left_n   = (k == KIND_WRITE) ? '0 : rl;
						held_error_n   = ST_OK;
						result.bus_cmd = CMD_START;
						phase_n        = PH_START;
						wait_ticks_n   = '0;
					end
				end
			end
			ACT_WRITE: begin
				if (phase_q == PH_NEED_DATA) begin
					writes_left_n   = writes_left_q - CNT_ONE;
					result.bus_cmd  = CMD_SEND;
					result.bus_byte = item_s1.data;
					phase_n         = PH_DATA_W;
					wait_ticks_n    = '0;
				end
			end
			ACT_COMPLETE: begin
				unique case (phase_q)
					PH_START: begin
						result.bus_cmd  = CMD_SEND;
						result.bus_byte = {target_addr_q, txn_kind_q == KIND_READ};
						phase_n         = (txn_kind_q == KIND_READ) ? PH_ADDR_R : PH_ADDR_W;
						wait_ticks_n    = '0;
					end
					PH_ADDR_W: begin
						wait_ticks_n = '0;
						if (item_s1.nack_seen) begin
							if (held_error_q == ST_OK) held_error_n = ST_NACK;
							result.bus_cmd = CMD_STOP;
							phase_n        = PH_STOP;
						end else begin
							phase_n = PH_NEED_DATA;
						end
					end
					PH_DATA_W: begin
						wait_ticks_n = '0;
						priority if (item_s1.nack_seen) begin
							if (held_error_q == ST_OK) held_error_n = ST_NACK;
							result.bus_cmd = CMD_STOP;
							phase_n        = PH_STOP;
						end else if (writes_left_q != '0) begin
							phase_n = PH_NEED_DATA;
						end else if (txn_kind_q == KIND_WR_RD) begin
							result.bus_cmd = CMD_RESTART;
							phase_n        = PH_RESTART;
						end else begin
							result.bus_cmd = CMD_STOP;
							phase_n        = PH_STOP;
						end
					end
					PH_RESTART: begin
						result.bus_cmd  = CMD_SEND;
						result.bus_byte = {target_addr_q, 1'b1};
						phase_n         = PH_ADDR_R;
						wait_ticks_n    = '0;
					end
					PH_ADDR_R: begin
						wait_ticks_n = '0;
						if (item_s1.nack_seen) begin
							if (held_error_q == ST_OK) held_error_n = ST_NACK;
							result.bus_cmd = CMD_STOP;
							phase_n        = PH_STOP;
						end else begin
							result.bus_cmd = (reads_left_q == CNT_ONE) ? CMD_RX_NACK
							                                            : CMD_RX_ACK;
							phase_n        = PH_DATA_R;
						end
					end
					PH_DATA_R: begin
						// receive completion: nack_seen has no meaning here
						result.read_valid = 1'b1;
						result.read_byte  = item_s1.data;
						reads_left_n      = rd_dec;
						wait_ticks_n      = '0;
						if (rd_dec != '0) begin
							result.bus_cmd = (rd_dec == CNT_ONE) ? CMD_RX_NACK : CMD_RX_ACK;
							phase_n        = PH_DATA_R;
						end else begin
							result.bus_cmd = CMD_STOP;
							phase_n        = PH_STOP;
						end
					end
					PH_STOP: begin
						result.bus_cmd  = CMD_RELEASE;
						result.done_res = 1'b1;
						result.status   = held_error_q;
						phase_n         = PH_IDLE;
						wait_ticks_n    = '0;
					end
					default: begin
						// idle or waiting for a write item: completion ignored
						phase_n = phase_q;
					end
				endcase
			end
			ACT_TICK: begin
				if (phase_q != PH_IDLE && phase_q != PH_NEED_DATA) begin
					if (ticks_inc < timeout_limit_q) begin
						wait_ticks_n = ticks_inc;
					end else if (phase_q == PH_STOP) begin
						// stop never completed: release with the held error, or timeout if none
						result.bus_cmd  = CMD_RELEASE;
						result.done_res = 1'b1;
						result.status   = (held_error_q == ST_OK) ? ST_TIMEOUT : held_error_q;
						phase_n         = PH_IDLE;
						wait_ticks_n    = '0;
					end else begin
						if (held_error_q == ST_OK) held_error_n = ST_TIMEOUT;
						result.bus_cmd = CMD_STOP;
						phase_n        = PH_STOP;
						wait_ticks_n   = '0;
					end
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase

		result.busy_res = (phase_n != PH_IDLE);
	end

	// sequencer state, updated as the item leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			txn_kind_q    <= KIND_WRITE;
			target_addr_q <= '0;
			writes_left_q <= '0;
			reads_left_q  <= '0;
			held_error_q  <= ST_OK;
			wait_ticks_q  <= '0;
		end else if (advance) begin
			phase_q       <= phase_n;
			txn_kind_q    <= txn_kind_n;
			target_addr_q <= target_addr_n;
			writes_left_q <= writes_left_n;
			reads_left_q  <= reads_left_n;
			held_error_q  <= held_error_n;
			wait_ticks_q  <= wait_ticks_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

endmodule

>>> dv/i2c_master_transaction_sequencer_core_tb.sv
module i2c_master_transaction_sequencer_core_tb import i2cms_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// quiet cycles (no handshake on any channel) before the run is declared hung
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	// long receiver hold-off that backs the sequencer up into its input
	localparam int unsigned RX_HOLD_CYCLES = 80;
	// items pass the core's input and result registers; allow a little slack on top
	localparam int unsigned SETTLE_CYCLES = 4;

	// shadow of the sequencer's internal state
	typedef struct packed {
		phase_t            ph;
		kind_t             kd;
		logic [6:0]        addr;
		logic [7:0]        wleft;
		logic [7:0]        rleft;
		status_t           err;
		logic [TICK_W-1:0] ticks;
	} seq_state_t;

	// one event waiting to be driven, with the gap the sender keeps after it
	typedef struct {
		in_item_t    ev;
		int unsigned gap;
	} pending_event_t;

	logic clk;
	logic arst_n;

	i2cms_in_if  evt_ch ();
	i2cms_out_if res_ch ();
	i2cms_cfg_if cfg_ch ();

	i2c_master_transaction_sequencer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// register copies, only changed while no item is in flight
	logic              cfg_enabled;
	logic [TICK_W-1:0] cfg_timeout;

	// gen_state runs ahead while events are queued, model_state follows acceptance
	seq_state_t gen_state;
	seq_state_t model_state;

	pending_event_t pending_events[$];
	out_item_t      pending_bus_results[$];
	pending_event_t next_pe;
	out_item_t      want_res;

	int unsigned queued_events   = 0;
	int unsigned accepted_events = 0;
	int unsigned mismatches      = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned tx_wait;
	int unsigned rx_wait;
	int unsigned tick_pct        = 20;
	bit          tx_burst        = 1'b0;
	bit          rx_burst        = 1'b0;
	bit          rx_hold;
	bit          hold_req        = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// sequencer prediction
	// ---------------------------------------------------------------

	// every command restarts the tick count
	function automatic void issue_bus_cmd(inout seq_state_t s, inout out_item_t r,
			input cmd_t c, input logic [7:0] b, input phase_t nxt);
		r.bus_cmd  = c;
		r.bus_byte = b;
		s.ph       = nxt;
		s.ticks    = '0;
	endfunction

	// first error sticks, later ones only force the stop
	function automatic void abort_with_stop(inout seq_state_t s, inout out_item_t r,
			input status_t e);
		if (s.err == ST_OK)
			s.err = e;
		issue_bus_cmd(s, r, CMD_STOP, 8'h00, PH_STOP);
	endfunction

	function automatic void release_bus(inout seq_state_t s, inout out_item_t r,
			input status_t st);
		r.bus_cmd  = CMD_RELEASE;
		r.done_res = 1'b1;
		r.status   = st;
		s.ph       = PH_IDLE;
		s.ticks    = '0;
	endfunction

	// nack goes out on the last byte of the read
	function automatic void request_receive(inout seq_state_t s, inout out_item_t r);
		issue_bus_cmd(s, r, (s.rleft == 8'd1) ? CMD_RX_NACK : CMD_RX_ACK, 8'h00, PH_DATA_R);
	endfunction

	function automatic out_item_t sequencer_next(inout seq_state_t s, input in_item_t ev);
		out_item_t r;
		status_t   verdict;
		r       = '0;
		verdict = ST_OK;
		case (action_t'(ev.action))
			ACT_BEGIN: begin
				// a begin while busy is dropped without a trace
				if (s.ph == PH_IDLE) begin
					if (ev.kind == KIND_RESERVED)
						verdict = ST_ARG;
					else if (!cfg_enabled)
						verdict = ST_STATE;
					else if ((ev.kind != KIND_READ && ev.wr_count == 8'd0) ||
							(ev.kind != KIND_WRITE && ev.rd_count == 8'd0))
						verdict = ST_ARG;
					if (verdict != ST_OK) begin
						r.done_res = 1'b1;
						r.status   = verdict;
					end else begin
						s.kd    = kind_t'(ev.kind);
						s.addr  = ev.tgt_addr;
						s.wleft = (ev.kind == KIND_READ) ? 8'd0 : ev.wr_count;
						s.rleft = (ev.kind == KIND_WRITE) ? 8'd0 : ev.rd_count;
						s.err   = ST_OK;
						issue_bus_cmd(s, r, CMD_START, 8'h00, PH_START);
					end
				end
			end
			ACT_WRITE: begin
				if (s.ph == PH_NEED_DATA) begin
					s.wleft = s.wleft - 8'd1;
					issue_bus_cmd(s, r, CMD_SEND, ev.data, PH_DATA_W);
				end
			end
			ACT_COMPLETE: begin
				case (s.ph)
					PH_START: begin
						if (s.kd == KIND_READ)
							issue_bus_cmd(s, r, CMD_SEND, {s.addr, 1'b1}, PH_ADDR_R);
						else
							issue_bus_cmd(s, r, CMD_SEND, {s.addr, 1'b0}, PH_ADDR_W);
					end
					PH_ADDR_W: begin
						if (ev.nack_seen)
							abort_with_stop(s, r, ST_NACK);
						else begin
							s.ph    = PH_NEED_DATA;
							s.ticks = '0;
						end
					end
					PH_DATA_W: begin
						if (ev.nack_seen)
							abort_with_stop(s, r, ST_NACK);
						else if (s.wleft != 8'd0) begin
							s.ph    = PH_NEED_DATA;
							s.ticks = '0;
						end else if (s.kd == KIND_WR_RD)
							issue_bus_cmd(s, r, CMD_RESTART, 8'h00, PH_RESTART);
						else
							issue_bus_cmd(s, r, CMD_STOP, 8'h00, PH_STOP);
					end
					PH_RESTART: issue_bus_cmd(s, r, CMD_SEND, {s.addr, 1'b1}, PH_ADDR_R);
					PH_ADDR_R: begin
						if (ev.nack_seen)
							abort_with_stop(s, r, ST_NACK);
						else
							request_receive(s, r);
					end
					PH_DATA_R: begin
						// nack_seen means nothing on a receive
						r.read_valid = 1'b1;
						r.read_byte  = ev.data;
						s.rleft      = s.rleft - 8'd1;
						if (s.rleft != 8'd0)
							request_receive(s, r);
						else
							issue_bus_cmd(s, r, CMD_STOP, 8'h00, PH_STOP);
					end
					PH_STOP: release_bus(s, r, s.err);
					default: ;
				endcase
			end
			default: begin
				// ticks only count while a completion is outstanding
				if (s.ph != PH_IDLE && s.ph != PH_NEED_DATA) begin
					s.ticks = s.ticks + 1'b1;
					if (s.ticks >= cfg_timeout) begin
						if (s.ph == PH_STOP)
							release_bus(s, r, (s.err == ST_OK) ? ST_TIMEOUT : s.err);
						else
							abort_with_stop(s, r, ST_TIMEOUT);
					end
				end
			end
		endcase
		r.busy_res = (s.ph != PH_IDLE);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	// queue an event; tells whether it did anything at all
	function automatic bit push_event(in_item_t ev);
		seq_state_t     prior_state;
		out_item_t      r;
		pending_event_t pe;
		prior_state = gen_state;
		r           = sequencer_next(gen_state, ev);
		if ($urandom_range(0, 24) == 0)
			tx_burst = !tx_burst;
		pe.ev  = ev;
		pe.gap = tx_burst ? 0 : $urandom_range(0, 5);
		pending_events.push_back(pe);
		queued_events++;
		return (gen_state != prior_state) || r.bus_cmd != CMD_NONE || r.done_res ||
				r.read_valid;
	endfunction

	function automatic void add_event(action_t a, kind_t k, logic [6:0] addr,
			logic [7:0] wl, logic [7:0] rl, logic [7:0] d, logic nk);
		in_item_t ev;
		ev.action    = a;
		ev.kind      = k;
		ev.tgt_addr  = addr;
		ev.wr_count  = wl;
		ev.rd_count  = rl;
		ev.data      = d;
		ev.nack_seen = nk;
		void'(push_event(ev));
	endfunction

	// mostly short transfers, now and then a longer one or a zero count
	function automatic logic [7:0] byte_count();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return 8'd0;
		if (roll < 12)
			return 8'($urandom_range(5, 16));
		return 8'($urandom_range(1, 4));
	endfunction

	// mostly a well-formed next step for the current phase, else random noise
	function automatic in_item_t random_event();
		in_item_t ev;
		ev.action    = 2'($urandom_range(0, 3));
		ev.kind      = 2'($urandom_range(0, 3));
		ev.tgt_addr  = 7'($urandom_range(0, 127));
		ev.wr_count  = 8'($urandom_range(0, 255));
		ev.rd_count  = 8'($urandom_range(0, 255));
		ev.data      = 8'($urandom_range(0, 255));
		ev.nack_seen = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 85) begin
			case (gen_state.ph)
				PH_IDLE: begin
					ev.action    = ACT_BEGIN;
					ev.kind      = ($urandom_range(0, 19) == 0) ? KIND_RESERVED :
							kind_t'($urandom_range(0, 2));
					ev.wr_count  = byte_count();
					ev.rd_count  = byte_count();
				end
				PH_NEED_DATA: ev.action = ACT_WRITE;
				default: begin
					ev.action    = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_COMPLETE;
					ev.nack_seen = ($urandom_range(0, 9) == 0);
				end
			endcase
		end else if (gen_state.ph == PH_IDLE && ev.action == ACT_BEGIN) begin
			// keep a stray begin from opening a very long transfer
			ev.wr_count[7:4] = '0;
			ev.rd_count[7:4] = '0;
		end
		return ev;
	endfunction

	// wait until every queued event is in and every result is out
	task automatic drain_sequencer();
		do
			@(posedge clk);
		while (accepted_events != queued_events || pending_bus_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_csr(reg_idx_t idx, logic [TICK_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_ENABLED)
			cfg_enabled = value[0];
		else
			cfg_timeout = value;
		@(posedge clk);
	endtask

	// one random phase under one register setting
	task automatic run_random(bit en, logic [TICK_W-1:0] lim, int unsigned n_useful,
			int unsigned tick_share, bit squeeze);
		int unsigned useful;
		useful = 0;
		drain_sequencer();
		write_csr(REG_ENABLED, TICK_W'(en));
		write_csr(REG_TIMEOUT, lim);
		tick_pct = tick_share;
		if (squeeze) begin
			tx_burst = 1'b1;
			hold_req = 1'b1;
		end
		while (useful < n_useful)
			useful += push_event(random_event());
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ENABLED;
		cfg_ch.data  = '0;
		cfg_enabled  = 1'b0;
		cfg_timeout  = TIMEOUT_RST;
		gen_state    = '0;
		model_state  = '0;
		arst_n       = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// disabled after reset: reserved kind is checked ahead of the enable
		add_event(ACT_BEGIN, KIND_WRITE, 7'h2A, 8'd3, 8'd0, 8'h00, 1'b0);
		add_event(ACT_BEGIN, KIND_RESERVED, 7'h2A, 8'd3, 8'd3, 8'h00, 1'b0);
		drain_sequencer();
		write_csr(REG_ENABLED, TICK_W'(1));

		// zero counts, one per kind
		add_event(ACT_BEGIN, KIND_WRITE, 7'h11, 8'd0, 8'd9, 8'h00, 1'b0);
		add_event(ACT_BEGIN, KIND_READ, 7'h11, 8'd4, 8'd0, 8'h00, 1'b0);
		add_event(ACT_BEGIN, KIND_WR_RD, 7'h11, 8'd3, 8'd0, 8'h00, 1'b0);
		// stray write byte, completion and tick while idle
		add_event(ACT_WRITE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h5A, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_TICK, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		// full write-then-read at the top address
		add_event(ACT_BEGIN, KIND_WR_RD, 7'h7F, 8'd1, 8'd2, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		// waiting for a byte: tick, completion and begin are all dropped
		add_event(ACT_TICK, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b1);
		add_event(ACT_BEGIN, KIND_WRITE, 7'h33, 8'd2, 8'd2, 8'h00, 1'b0);
		add_event(ACT_WRITE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'hFF, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		// nack flag on a receive completion has no effect
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'hA5, 1'b1);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		// longest write, cut short by an address nack
		add_event(ACT_BEGIN, KIND_WRITE, 7'h00, 8'd255, 8'd255, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b1);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);

		// timeouts at a limit of 1: plain timeout, then stop timeout after a nack
		drain_sequencer();
		write_csr(REG_TIMEOUT, TICK_W'(1));
		add_event(ACT_BEGIN, KIND_READ, 7'h55, 8'd0, 8'd1, 8'h00, 1'b0);
		add_event(ACT_TICK, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_TICK, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_BEGIN, KIND_WRITE, 7'h12, 8'd2, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);
		add_event(ACT_COMPLETE, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b1);
		add_event(ACT_TICK, KIND_WRITE, 7'h00, 8'd0, 8'd0, 8'h00, 1'b0);

		// random phases; each one starts only after the previous has fully drained
		run_random(1'b1, TICK_W'(131071), 130, 15, 1'b0);
		run_random(1'b1, TICK_W'(1), 60, 20, 1'b0);
		run_random(1'b1, TICK_W'(4), 160, 45, 1'b1);
		run_random(1'b0, TICK_W'(4), 30, 20, 1'b0);
		run_random(1'b1, TICK_W'(0), 40, 10, 1'b0);
		run_random(1'b1, TICK_W'($urandom_range(2, 12)), 150, 35, 1'b0);
		drain_sequencer();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------
	// driver: event channel
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
			evt_ch.item  <= '0;
			tx_wait      <= 0;
		end else if (!evt_ch.valid || evt_ch.ready) begin
			if (tx_wait != 0) begin
				evt_ch.valid <= 1'b0;
				tx_wait      <= tx_wait - 1;
			end else if (pending_events.size() != 0) begin
				next_pe       = pending_events.pop_front();
				evt_ch.valid <= 1'b1;
				evt_ch.item  <= next_pe.ev;
				tx_wait      <= next_pe.gap;
			end else
				evt_ch.valid <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// monitor: result check, then prediction for the accepted event
	// ---------------------------------------------------------------
	function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_bus_results.size() == 0) begin
					$error("result with no event outstanding, bus_cmd %0d",
							res_ch.item.bus_cmd);
					mismatches++;
				end else begin
					want_res = pending_bus_results.pop_front();
					check_field("bus_cmd", want_res.bus_cmd, res_ch.item.bus_cmd);
					check_field("bus_byte", want_res.bus_byte, res_ch.item.bus_byte);
					check_field("read_valid", want_res.read_valid, res_ch.item.read_valid);
					check_field("read_byte", want_res.read_byte, res_ch.item.read_byte);
					check_field("done_res", want_res.done_res, res_ch.item.done_res);
					check_field("status", want_res.status, res_ch.item.status);
					check_field("busy_res", want_res.busy_res, res_ch.item.busy_res);
				end
				// switch between stall-free stretches and random stalls
				if ($urandom_range(0, 29) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
			end else if (rx_wait != 0)
				rx_wait--;
			res_ch.ready <= (rx_wait == 0) && !rx_hold;
			if (evt_ch.valid && evt_ch.ready) begin
				pending_bus_results.push_back(sequencer_next(model_state, evt_ch.item));
				accepted_events++;
			end
		end
	end

	// one long hold-off on the result side while the sender keeps pushing
	initial begin
		rx_hold = 1'b0;
		wait (hold_req);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// hang detection: no handshake anywhere for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

>>> sim.f
rtl/core/i2cms_pkg.sv
rtl/core/i2cms_if.sv
rtl/core/i2c_master_transaction_sequencer_core.sv
dv/i2c_master_transaction_sequencer_core_tb.sv
